>>> hdl/grc_pkg.sv
// shared constants, types and helper functions of the grid ray caster
package grc_pkg;

  // map and screen geometry
  localparam int MAP_SIZE      = 32;
  localparam int MAP_BITS      = $clog2(MAP_SIZE);
  localparam int ADDR_W        = 2 * MAP_BITS;
  localparam int MAP_DEPTH     = MAP_SIZE * MAP_SIZE;
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int TEX_SIZE      = 64;
  localparam int TEX_BITS      = $clog2(TEX_SIZE);

  // fixed point widths
  localparam int Q       = 16;
  localparam int POS_W   = 21;
  localparam int DIR_W   = 18;
  localparam int RAY_W   = 22;
  localparam int CAMX_W  = 20;
  localparam int CELL_W  = MAP_BITS + 2;
  localparam int NUM_W   = 24;
  localparam int DIST_W  = 49;
  localparam int PERP_W  = 24;
  localparam int TILE_W  = 8;
  localparam int COL_W   = 10;
  localparam int LEN_W   = 10;
  localparam int COLOR_W = 24;

  localparam logic [DIST_W-1:0]  DIST_INF    = DIST_W'(1) << (DIST_W - 1);
  localparam logic [PERP_W-1:0]  PERP_MAX    = '1;
  localparam logic [COLOR_W-1:0] Y_SIDE_MASK = 24'h7f7f7f;
  localparam logic [COLOR_W-1:0] NO_MASK     = '1;

  // shared divider and multiplier widths
  localparam int DIV_N   = 40;
  localparam int DIV_D   = 24;
  localparam int DIV_CNT = $clog2(DIV_N + 1);
  localparam int MUL_A   = 25;
  localparam int MUL_B   = 34;
  localparam int MUL_P   = MUL_A + MUL_B;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = POS_W;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_PLANE_Y = 3'd5;

  // request kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD,
    OP_MUL_CAMX, OP_CAP_CAMX,
    OP_MUL_RX, OP_CAP_RX, OP_MUL_RY, OP_CAP_RY,
    OP_DIV_DX, OP_CAP_DX, OP_DIV_DY, OP_CAP_DY,
    OP_MUL_SDX, OP_CAP_SDX, OP_MUL_SDY, OP_CAP_SDY,
    OP_STEP,
    OP_DIV_PERP, OP_CAP_PERP, OP_DIV_LEN, OP_CAP_LEN,
    OP_MUL_HIT, OP_CAP_RESULT
  } op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic clear_last;
    logic div_busy;
    logic walk_end;
    logic out_free;
  } dp_stat_t;

  // magnitude of a ray component
  function automatic logic [RAY_W-1:0] abs_ray(input logic signed [RAY_W-1:0] r);
    abs_ray = r[RAY_W-1] ? RAY_W'(-r) : RAY_W'(r);
  endfunction

  // flat colour per wall code
  function automatic logic [COLOR_W-1:0] code_color(input logic [TILE_W-1:0] code);
    case (code)
      8'd1:    code_color = 24'hff0000;
      8'd2:    code_color = 24'h00ff00;
      8'd3:    code_color = 24'h0000ff;
      8'd4:    code_color = 24'hffff00;
      8'd5:    code_color = 24'h00ffff;
      default: code_color = 24'h0000ff;
    endcase
  endfunction

endpackage

>>> hdl/grc_ctrl.sv
// sequencing state machine of the ray caster
module grc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  input  grc_pkg::dp_stat_t stat,
  output grc_pkg::op_t      op
);
  import grc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_CAMX, S_CAMX_C,
    S_RX_M, S_RX_C, S_RY_M, S_RY_C,
    S_DX, S_DX_W, S_DX_C, S_DY, S_DY_W, S_DY_C,
    S_SDX_M, S_SDX_C, S_SDY_M, S_SDY_C,
    S_STEP, S_CHECK,
    S_PERP, S_PERP_W, S_PERP_C, S_LEN, S_LEN_W, S_LEN_C,
    S_HIT_M, S_FIN
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR:  if (stat.clear_last) state <= S_IDLE;
        S_IDLE:   if (in_valid && in_cmd == CMD_CAST) state <= S_CAMX;
        S_CAMX:   state <= S_CAMX_C;
        S_CAMX_C: state <= S_RX_M;
        S_RX_M:   state <= S_RX_C;
        S_RX_C:   state <= S_RY_M;
        S_RY_M:   state <= S_RY_C;
        S_RY_C:   state <= S_DX;
        S_DX:     state <= S_DX_W;
        S_DX_W:   if (!stat.div_busy) state <= S_DX_C;
        S_DX_C:   state <= S_DY;
        S_DY:     state <= S_DY_W;
        S_DY_W:   if (!stat.div_busy) state <= S_DY_C;
        S_DY_C:   state <= S_SDX_M;
        S_SDX_M:  state <= S_SDX_C;
        S_SDX_C:  state <= S_SDY_M;
        S_SDY_M:  state <= S_SDY_C;
        S_SDY_C:  state <= S_STEP;
        S_STEP:   state <= S_CHECK;
        S_CHECK:  state <= stat.walk_end ? S_PERP : S_STEP;
        S_PERP:   state <= S_PERP_W;
        S_PERP_W: if (!stat.div_busy) state <= S_PERP_C;
        S_PERP_C: state <= S_LEN;
        S_LEN:    state <= S_LEN_W;
        S_LEN_W:  if (!stat.div_busy) state <= S_LEN_C;
        S_LEN_C:  state <= S_HIT_M;
        S_HIT_M:  state <= S_FIN;
        S_FIN:    if (stat.out_free) state <= S_IDLE;
        default:  state <= S_CLEAR;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  // operation decode
  always_comb begin
    unique case (state)
      S_CLEAR:  op = OP_CLEAR;
      S_IDLE:   op = in_valid ? OP_LOAD : OP_NONE;
      S_CAMX:   op = OP_MUL_CAMX;
      S_CAMX_C: op = OP_CAP_CAMX;
      S_RX_M:   op = OP_MUL_RX;
      S_RX_C:   op = OP_CAP_RX;
      S_RY_M:   op = OP_MUL_RY;
      S_RY_C:   op = OP_CAP_RY;
      S_DX:     op = OP_DIV_DX;
      S_DX_C:   op = OP_CAP_DX;
      S_DY:     op = OP_DIV_DY;
      S_DY_C:   op = OP_CAP_DY;
      S_SDX_M:  op = OP_MUL_SDX;
      S_SDX_C:  op = OP_CAP_SDX;
      S_SDY_M:  op = OP_MUL_SDY;
      S_SDY_C:  op = OP_CAP_SDY;
      S_STEP:   op = OP_STEP;
      S_PERP:   op = OP_DIV_PERP;
      S_PERP_C: op = OP_CAP_PERP;
      S_LEN:    op = OP_DIV_LEN;
      S_LEN_C:  op = OP_CAP_LEN;
      S_HIT_M:  op = OP_MUL_HIT;
      S_FIN:    op = stat.out_free ? OP_CAP_RESULT : OP_NONE;
      default:  op = OP_NONE;
    endcase
  end

endmodule

>>> hdl/grc_dp.sv
// datapath of the ray caster: registers, tile map, divider, multiplier, walk
module grc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  grc_pkg::op_t                      op,
  output grc_pkg::dp_stat_t                 stat,
  input  logic                              cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [grc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_cmd,
  input  logic [grc_pkg::MAP_BITS-1:0]      in_cell_x,
  input  logic [grc_pkg::MAP_BITS-1:0]      in_cell_y,
  input  logic [grc_pkg::TILE_W-1:0]        in_tile,
  input  logic [grc_pkg::COL_W-1:0]         in_col,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [grc_pkg::COL_W-1:0]         out_col,
  output logic [grc_pkg::TILE_W-1:0]        out_kind,
  output logic                              out_side,
  output logic [grc_pkg::PERP_W-1:0]        out_perp,
  output logic [grc_pkg::LEN_W-1:0]         out_len,
  output logic [grc_pkg::TEX_BITS-1:0]      out_tex,
  output logic [grc_pkg::COLOR_W-1:0]       out_color
);
  import grc_pkg::*;

  localparam logic [DIV_N-1:0]  RECIP_NUM = DIV_N'(1) << (2 * Q);
  localparam logic [DIV_N-1:0]  LEN_NUM   = DIV_N'(SCREEN_HEIGHT) << Q;
  localparam logic [NUM_W-1:0]  ONE_NUM   = NUM_W'(1) << Q;
  localparam logic [CAMX_W-1:0] ONE_CAMX  = CAMX_W'(1) << Q;
  localparam logic [Q:0]        ONE_FRAC  = (Q+1)'(1) << Q;

  // col * 2^17 / 320 = col * 2^11 / 5, taken as (col * ceil(2^24 / 5)) >> 13
  localparam logic signed [MUL_B-1:0] CAMX_RECIP = MUL_B'(3355444);
  localparam int                      CAMX_SH    = 13;

  // camera registers
  logic        [POS_W-1:0] cam_pos_x, cam_pos_y;
  logic signed [DIR_W-1:0] view_dir_x, view_dir_y, view_plane_x, view_plane_y;

  // ray state
  logic        [COL_W-1:0]  col_r;
  logic signed [CAMX_W-1:0] camx;
  logic signed [RAY_W-1:0]  rx, ry;
  logic        [DIST_W-1:0] dx, dy, sdx, sdy;
  logic signed [CELL_W-1:0] mx, my;
  logic                     side;
  logic        [PERP_W-1:0] perp;
  logic        [LEN_W-1:0]  len;

  // tile map and clearing pass
  logic [TILE_W-1:0] tile_map [MAP_DEPTH];
  logic [ADDR_W-1:0] clr_idx;
  logic [TILE_W-1:0] rd_tile;
  logic              oob;

  // shared divider
  logic [DIV_N-1:0]   quo;
  logic [DIV_D:0]     rem;
  logic [DIV_D-1:0]   dvs;
  logic [DIV_CNT-1:0] div_cnt;
  logic               div_busy;

  // shared multiplier
  logic signed [MUL_P-1:0] prod;
  logic signed [MUL_A-1:0] mul_a;
  logic signed [MUL_B-1:0] mul_b;

  // combinational helpers
  logic [RAY_W-1:0]         abs_rx, abs_ry, abs_rs;
  logic [Q:0]               frac_x, frac_y;
  logic                     step_x;
  logic signed [CELL_W-1:0] mx_step, my_step, nx, ny;
  logic [DIST_W:0]          sum_x, sum_y;
  logic signed [CELL_W-1:0] ax;
  logic [POS_W-1:0]         pos_s, pos_o;
  logic signed [RAY_W-1:0]  r_sel;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         num_abs;
  logic                     perp_neg;
  logic [DIV_N-1:0]         div_num;
  logic [DIV_D-1:0]         div_den;
  logic                     div_start;
  logic [DIV_D:0]           rem_sh;
  logic                     rem_ge;
  logic [Q-1:0]             hit_frac;
  logic [TEX_BITS-1:0]      tex_raw;
  logic                     mirror;
  logic [TILE_W-1:0]        kind;

  assign abs_rx = abs_ray(rx);
  assign abs_ry = abs_ray(ry);

  // distance to the first grid line on each axis
  assign frac_x = rx[RAY_W-1] ? {1'b0, cam_pos_x[Q-1:0]} : ONE_FRAC - {1'b0, cam_pos_x[Q-1:0]};
  assign frac_y = ry[RAY_W-1] ? {1'b0, cam_pos_y[Q-1:0]} : ONE_FRAC - {1'b0, cam_pos_y[Q-1:0]};

  // walk step selection
  assign step_x  = sdx < sdy;
  assign mx_step = rx[RAY_W-1] ? mx - CELL_W'(1) : mx + CELL_W'(1);
  assign my_step = ry[RAY_W-1] ? my - CELL_W'(1) : my + CELL_W'(1);
  assign nx      = step_x ? mx_step : mx;
  assign ny      = step_x ? my : my_step;
  assign sum_x   = {1'b0, sdx} + {1'b0, dx};
  assign sum_y   = {1'b0, sdy} + {1'b0, dy};

  // distance from camera to the entered grid line
  assign ax      = side ? my : mx;
  assign pos_s   = side ? cam_pos_y : cam_pos_x;
  assign pos_o   = side ? cam_pos_x : cam_pos_y;
  assign r_sel   = side ? ry : rx;
  assign abs_rs  = side ? abs_ry : abs_rx;
  assign num     = NUM_W'(signed'({ax, {Q{1'b0}}})) - NUM_W'(pos_s)
                 + (r_sel[RAY_W-1] ? ONE_NUM : '0);
  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign perp_neg = (num[NUM_W-1] != r_sel[RAY_W-1]) && (num != '0);

  // divider operand selection
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    case (op)
      OP_DIV_DX: begin
        div_num = RECIP_NUM;
        div_den = DIV_D'(abs_rx);
      end
      OP_DIV_DY: begin
        div_num = RECIP_NUM;
        div_den = DIV_D'(abs_ry);
      end
      OP_DIV_PERP: begin
        div_num = DIV_N'({num_abs, {Q{1'b0}}});
        div_den = DIV_D'(abs_rs);
      end
      OP_DIV_LEN: begin
        div_num = LEN_NUM;
        div_den = DIV_D'(perp);
      end
      default: div_start = 1'b0;
    endcase
  end

  // restoring division step
  assign rem_sh = {rem[DIV_D-1:0], quo[DIV_N-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= DIV_CNT'(DIV_N);
    end else if (div_busy) begin
      div_cnt <= div_cnt - DIV_CNT'(1);
      if (div_cnt == DIV_CNT'(1)) div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      quo <= div_num;
      rem <= '0;
      dvs <= div_den;
    end else if (div_busy) begin
      quo <= {quo[DIV_N-2:0], rem_ge};
      rem <= rem_ge ? rem_sh - {1'b0, dvs} : rem_sh;
    end
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_MUL_CAMX: begin
        mul_a = signed'(MUL_A'(col_r));
        mul_b = CAMX_RECIP;
      end
      OP_MUL_RX: begin
        mul_a = MUL_A'(view_plane_x);
        mul_b = MUL_B'(camx);
      end
      OP_MUL_RY: begin
        mul_a = MUL_A'(view_plane_y);
        mul_b = MUL_B'(camx);
      end
      OP_MUL_SDX: begin
        mul_a = signed'(MUL_A'(frac_x));
        mul_b = signed'(MUL_B'(dx[2*Q:0]));
      end
      OP_MUL_SDY: begin
        mul_a = signed'(MUL_A'(frac_y));
        mul_b = signed'(MUL_B'(dy[2*Q:0]));
      end
      OP_MUL_HIT: begin
        mul_a = signed'(MUL_A'(perp));
        mul_b = side ? MUL_B'(rx) : MUL_B'(ry);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product holds until the next multiply, the hit product is read while the result waits
  always_ff @(posedge clk) begin
    case (op) inside
      OP_MUL_CAMX, OP_MUL_RX, OP_MUL_RY, OP_MUL_SDX, OP_MUL_SDY, OP_MUL_HIT:
        prod <= mul_a * mul_b;
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_pos_x    <= POS_W'(1441792);
      cam_pos_y    <= POS_W'(786432);
      view_dir_x   <= -DIR_W'(65536);
      view_dir_y   <= '0;
      view_plane_x <= '0;
      view_plane_y <= DIR_W'(43254);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CAM_POS_X:    cam_pos_x    <= cfg_data;
        REG_CAM_POS_Y:    cam_pos_y    <= cfg_data;
        REG_VIEW_DIR_X:   view_dir_x   <= signed'(cfg_data[DIR_W-1:0]);
        REG_VIEW_DIR_Y:   view_dir_y   <= signed'(cfg_data[DIR_W-1:0]);
        REG_VIEW_PLANE_X: view_plane_x <= signed'(cfg_data[DIR_W-1:0]);
        REG_VIEW_PLANE_Y: view_plane_y <= signed'(cfg_data[DIR_W-1:0]);
        default: ;
      endcase
    end
  end

  // tile map: one write port, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (op == OP_CLEAR) begin
      tile_map[clr_idx] <= '0;
    end else if (op == OP_LOAD && in_cmd == CMD_WRITE) begin
      tile_map[{in_cell_x, in_cell_y}] <= in_tile;
    end
    if (op == OP_STEP) begin
      rd_tile <= tile_map[{nx[MAP_BITS-1:0], ny[MAP_BITS-1:0]}];
      oob     <= (nx[CELL_W-1:MAP_BITS] != '0) || (ny[CELL_W-1:MAP_BITS] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (op == OP_CLEAR) begin
      clr_idx <= clr_idx + ADDR_W'(1);
    end
  end

  // ray setup, walk and distance
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        col_r <= in_col;
        mx    <= signed'(CELL_W'(cam_pos_x[POS_W-1:Q]));
        my    <= signed'(CELL_W'(cam_pos_y[POS_W-1:Q]));
      end
      OP_CAP_CAMX: camx <= signed'(CAMX_W'(prod >>> CAMX_SH) - ONE_CAMX);
      OP_CAP_RX:   rx <= RAY_W'(view_dir_x) + RAY_W'(prod >>> Q);
      OP_CAP_RY:   ry <= RAY_W'(view_dir_y) + RAY_W'(prod >>> Q);
      OP_CAP_DX:   dx <= (abs_rx == '0) ? DIST_INF : DIST_W'(quo[2*Q:0]);
      OP_CAP_DY:   dy <= (abs_ry == '0) ? DIST_INF : DIST_W'(quo[2*Q:0]);
      OP_CAP_SDX:  sdx <= dx[DIST_W-1] ? DIST_INF : DIST_W'(prod >>> Q);
      OP_CAP_SDY:  sdy <= dy[DIST_W-1] ? DIST_INF : DIST_W'(prod >>> Q);
      OP_STEP: begin
        if (step_x) begin
          sdx  <= (sum_x > {1'b0, DIST_INF}) ? DIST_INF : sum_x[DIST_W-1:0];
          mx   <= mx_step;
          side <= 1'b0;
        end else begin
          sdy  <= (sum_y > {1'b0, DIST_INF}) ? DIST_INF : sum_y[DIST_W-1:0];
          my   <= my_step;
          side <= 1'b1;
        end
      end
      OP_CAP_PERP: begin
        if (abs_rs == '0) perp <= PERP_MAX;
        else if (perp_neg) perp <= '0;
        else if (quo[DIV_N-1:PERP_W] != '0) perp <= PERP_MAX;
        else perp <= quo[PERP_W-1:0];
      end
      OP_CAP_LEN: begin
        if (perp == '0 || quo > DIV_N'(SCREEN_HEIGHT)) len <= LEN_W'(SCREEN_HEIGHT);
        else len <= quo[LEN_W-1:0];
      end
      default: ;
    endcase
  end

  // texture column and wall code
  assign hit_frac = pos_o[Q-1:0] + prod[2*Q-1:Q];
  assign tex_raw  = hit_frac[Q-1 -: TEX_BITS];
  assign mirror   = side ? ry[RAY_W-1] : (!rx[RAY_W-1] && rx != '0);
  assign kind     = oob ? '0 : rd_tile;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !out_ready) || (op == OP_CAP_RESULT);
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_CAP_RESULT) begin
      out_col   <= col_r;
      out_kind  <= kind;
      out_side  <= side;
      out_perp  <= perp;
      out_len   <= len;
      out_tex   <= mirror ? ~tex_raw : tex_raw;
      out_color <= code_color(kind) & (side ? Y_SIDE_MASK : NO_MASK);
    end
  end

  // status to the controller
  assign stat.clear_last = (clr_idx == ADDR_W'(MAP_DEPTH - 1));
  assign stat.div_busy   = div_busy;
  assign stat.walk_end   = oob || (rd_tile != '0);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

>>> hdl/grid_ray_caster_column.sv
// top level of the grid ray caster: stream ports, controller and datapath
//
// A tile write request is written into the map straight from idle. For a
// cast request, four divisions run one after another on a shared restoring
// divider (both reciprocals, wall distance, line height), camera x comes
// from a reciprocal multiplication, and each walk step is one read of the
// tile map; a ray can walk across the whole 32 x 32 map. After reset the
// block clears all 1024 tiles of the map, one tile per cycle, and takes no
// request until done; configuration writes are taken at any time. A finished
// result waits in the output register while the next request is accepted.
module grid_ray_caster_column (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [grc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cell_x, cell_y, tile_value, screen_col, zero fill
  input  logic [31:0]                   s_axis_tdata,
  // cmd
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_col, wall_kind, hit_side, perp_dist, line_len, tex_col, flat_color, zero fill
  output logic [87:0]                   m_axis_tdata
);
  import grc_pkg::*;

  op_t      op;
  dp_stat_t stat;

  logic [COL_W-1:0]    out_col;
  logic [TILE_W-1:0]   out_kind;
  logic                out_side;
  logic [PERP_W-1:0]   out_perp;
  logic [LEN_W-1:0]    out_len;
  logic [TEX_BITS-1:0] out_tex;
  logic [COLOR_W-1:0]  out_color;

  // controller
  grc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .op       (op)
  );

  // datapath
  grc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_cmd    (s_axis_tuser),
    .in_cell_x (s_axis_tdata[4:0]),
    .in_cell_y (s_axis_tdata[9:5]),
    .in_tile   (s_axis_tdata[17:10]),
    .in_col    (s_axis_tdata[27:18]),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_col   (out_col),
    .out_kind  (out_kind),
    .out_side  (out_side),
    .out_perp  (out_perp),
    .out_len   (out_len),
    .out_tex   (out_tex),
    .out_color (out_color)
  );

  // result packing
  assign m_axis_tdata = {5'b0, out_color, out_tex, out_len, out_perp,
                         out_side, out_kind, out_col};

endmodule
